// File: rtl/masked_byte_pattern_scanner_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scanner
// Implication checks under the asynchronous reset, reported by $error.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, command codes and types of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

	// Default sizes
	localparam int unsigned PATTERN_MAX_DEF  = 32;
	localparam int unsigned ADDRESS_BITS_DEF = 48;

	// Fixed field widths
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned PIDX_W   = 5;
	localparam int unsigned PLEN_W   = 6;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DATA_W = 32;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MATCHES    = 4'd1;

	// State update for one accepted request
	typedef struct packed {
		logic              take;
		logic [CMD_W-1:0]  cmd;
		logic [PIDX_W-1:0] pidx;
		logic [7:0]        value;
		logic [7:0]        mask;
		logic              seg;
	} upd_t;

endpackage

// File: rtl/mbps_channels.sv
// ----------------------------------------------------------------------------
// mbps channels
// Valid/ready channel interfaces: scan requests, match results, config writes.
// ----------------------------------------------------------------------------
interface mbps_scan_if import mbps_pkg::*; #(
	parameter int unsigned ADDR_W = ADDRESS_BITS_DEF
);
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [PIDX_W-1:0] pattern_index;
	logic [7:0]        byte_value;
	logic [7:0]        byte_mask;
	logic              segment_start;
	logic [ADDR_W-1:0] byte_address;

	modport source (
		output valid, command, pattern_index, byte_value, byte_mask, segment_start,
			byte_address,
		input  ready
	);
	modport sink (
		input  valid, command, pattern_index, byte_value, byte_mask, segment_start,
			byte_address,
		output ready
	);
endinterface

interface mbps_match_if import mbps_pkg::*; #(
	parameter int unsigned ADDR_W = ADDRESS_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  match_address;
	logic [COUNT_W-1:0] match_number;
	logic               limit_reached;

	modport source (
		output valid, match_address, match_number, limit_reached,
		input  ready
	);
	modport sink (
		input  valid, match_address, match_number, limit_reached,
		output ready
	);
endinterface

interface mbps_cfg_if import mbps_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: rtl/mbps_window.sv
// ----------------------------------------------------------------------------
// mbps_window
// Pattern store, recent byte line and segment fill; parallel masked compare.
// ----------------------------------------------------------------------------
module mbps_window import mbps_pkg::*; #(
	parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  upd_t             upd,
	input  logic [LEN_W-1:0] used_len,
	output logic             hit
);

	logic [7:0]       pat_q    [PATTERN_MAX];
	logic [7:0]       msk_q    [PATTERN_MAX];
	logic [7:0]       recent_q [PATTERN_MAX];
	logic [LEN_W-1:0] fill_q;
	logic [7:0]       win_b    [PATTERN_MAX];
	logic             all_eq;

	// Load pattern entries and shift scanned bytes in, newest at entry 0
	always_ff @(posedge clk) begin
		if (upd.take) begin
			case (upd.cmd)
				CMD_LOAD: begin
					for (int k = 0; k < PATTERN_MAX; k++) begin
						if (int'(upd.pidx) == k) begin
							pat_q[k] <= upd.value;
							msk_q[k] <= upd.mask;
						end
					end
				end
				CMD_SCAN: begin
					for (int k = PATTERN_MAX - 1; k > 0; k--) begin
						recent_q[k] <= recent_q[k-1];
					end
					recent_q[0] <= upd.value;
				end
				default: ;
			endcase
		end
	end

	// Track how many bytes of the current segment sit in the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (upd.take) begin
			case (upd.cmd)
				CMD_CLEAR: fill_q <= '0;
				CMD_SCAN: begin
					if (upd.seg) begin
						fill_q <= LEN_W'(1);
					end else if (fill_q != LEN_W'(PATTERN_MAX)) begin
						fill_q <= fill_q + LEN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Align window position j (oldest first) with recent entry used_len-1-j
	always_comb begin
		all_eq = 1'b1;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			win_b[j] = '0;
			for (int k = 0; k < PATTERN_MAX; k++) begin
				if (int'(used_len) - 1 - j == k) begin
					win_b[j] = recent_q[k];
				end
			end
			if (j < int'(used_len) && ((win_b[j] & msk_q[j]) != pat_q[j])) begin
				all_eq = 1'b0;
			end
		end
	end

	assign hit = (fill_q >= used_len) && all_eq;

endmodule

// File: rtl/mbps_report.sv
// ----------------------------------------------------------------------------
// mbps_report
// Request register, match counter with limit, and the result register.
// ----------------------------------------------------------------------------
module mbps_report import mbps_pkg::*; #(
	parameter int unsigned PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF,
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_take,
	input  logic [CMD_W-1:0]        in_cmd,
	input  logic [ADDRESS_BITS-1:0] in_addr,
	output logic                    in_ready,
	input  logic                    window_hit,
	input  logic [LEN_W-1:0]        used_len,
	input  logic [COUNT_W-1:0]      max_matches,
	mbps_match_if.source            match_out
);

	`include "masked_byte_pattern_scanner_core_assert.svh"

	logic                    valid_s1;
	logic [CMD_W-1:0]        cmd_s1;
	logic [ADDRESS_BITS-1:0] addr_s1;
	logic [COUNT_W-1:0]      count_q;
	logic                    match_valid_q;
	logic [ADDRESS_BITS-1:0] match_address_q;
	logic [COUNT_W-1:0]      match_number_q;
	logic                    limit_reached_q;
	logic                    advance;
	logic                    blocked;
	logic                    report;
	logic [COUNT_W-1:0]      count_next;

	// Stage 1 moves on when the result register is free or being taken
	assign advance  = !match_valid_q || match_out.ready;
	assign in_ready = !valid_s1 || advance;

	assign blocked    = (max_matches != '0) && (count_q >= max_matches);
	assign report     = valid_s1 && (cmd_s1 == CMD_SCAN) && window_hit && !blocked;
	assign count_next = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

	// Hold the accepted request for the compare cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1  <= in_cmd;
			addr_s1 <= in_addr;
		end
	end

	// Advance the match counter; clear drops it to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (valid_s1 && advance) begin
			if (cmd_s1 == CMD_CLEAR) begin
				count_q <= '0;
			end else if (report) begin
				count_q <= count_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_valid_q <= 1'b0;
		end else if (advance) begin
			match_valid_q <= report;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && report) begin
			match_address_q <= addr_s1 - ADDRESS_BITS'(used_len - LEN_W'(1));
			match_number_q  <= count_next;
			limit_reached_q <= (max_matches != '0) && (count_next == max_matches);
		end
	end

	assign match_out.valid         = match_valid_q;
	assign match_out.match_address = match_address_q;
	assign match_out.match_number  = match_number_q;
	assign match_out.limit_reached = limit_reached_q;

	`MBPS_ASSERT_NOW(a_number_nonzero, clk, arst_n, match_valid_q, match_number_q != '0, "match number zero")
	`MBPS_ASSERT_NOW(a_limit_consistent, clk, arst_n, match_valid_q && limit_reached_q, match_number_q == max_matches, "limit flag without count at limit")
	`MBPS_ASSERT_NEXT(a_clear_count, clk, arst_n, valid_s1 && (cmd_s1 == CMD_CLEAR) && advance, count_q == '0, "count not cleared")
	`MBPS_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && match_valid_q, "stall without pending work")

endmodule

// File: rtl/masked_byte_pattern_scanner_core.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core
// Wildcard byte pattern search over a stream of addressed memory bytes.
// ----------------------------------------------------------------------------
// The core takes one request per clock cycle (clear, load pattern byte, or
// scan byte), and each scan's result passes through the request register,
// where the full window is compared against the masked pattern in parallel,
// and then the result register. Input is held off
// only while a request and a finished match both wait on a stalled output;
// with the output drained the rate is one byte per cycle. A match reports the
// address of the window's first byte, its ordinal since the last clear and
// whether it reached max_matches. Configuration writes are always ready and
// must be issued only while no request is in flight.
module masked_byte_pattern_scanner_core import mbps_pkg::*; #(
	parameter int unsigned PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mbps_scan_if.sink    scan_in,
	mbps_match_if.source match_out,
	mbps_cfg_if.sink     cfg
);

	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

	logic [PLEN_W-1:0]  pattern_length_q;
	logic [COUNT_W-1:0] max_matches_q;
	logic [LEN_W-1:0]   used_len;
	logic               in_take;
	logic               in_ready;
	logic               window_hit;
	upd_t               upd;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PLEN_W'(1);
			max_matches_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg.data[PLEN_W-1:0];
				REG_MAX_MATCHES:    max_matches_q    <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the pattern length into 1..PATTERN_MAX
	always_comb begin
		if (pattern_length_q == '0) begin
			used_len = LEN_W'(1);
		end else if (int'(pattern_length_q) > int'(PATTERN_MAX)) begin
			used_len = LEN_W'(PATTERN_MAX);
		end else begin
			used_len = LEN_W'(pattern_length_q);
		end
	end

	// Accepted request updates the window state at once
	assign scan_in.ready = in_ready;
	assign in_take       = scan_in.valid && in_ready;

	assign upd.take  = in_take;
	assign upd.cmd   = scan_in.command;
	assign upd.pidx  = scan_in.pattern_index;
	assign upd.value = scan_in.byte_value;
	assign upd.mask  = scan_in.byte_mask;
	assign upd.seg   = scan_in.segment_start;

	mbps_window #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.used_len (used_len),
		.hit      (window_hit)
	);

	mbps_report #(
		.PATTERN_MAX  (PATTERN_MAX),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_report (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.in_cmd      (scan_in.command),
		.in_addr     (scan_in.byte_address),
		.in_ready    (in_ready),
		.window_hit  (window_hit),
		.used_len    (used_len),
		.max_matches (max_matches_q),
		.match_out   (match_out)
	);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked byte pattern scanner core. A directed
// table covers command codes, field extremes and care-mask corner cases;
// randomized phases then plant masked patterns into addressed segments, some
// wrapping the address, under several length and limit settings. Every match
// result is checked field by field against its typed result or an in-bench
// predictor, with random idling on both channels and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
	import mbps_pkg::*;

	localparam int unsigned PMAX = PATTERN_MAX_DEF;
	localparam int unsigned AW = ADDRESS_BITS_DEF;
	localparam int unsigned CLK_PERIOD = 20;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned HOLD_OFF_CYCLES = 80;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned STALL_LIMIT = 2000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [PIDX_W-1:0] pidx;
		logic [7:0]        value;
		logic [7:0]        mask;
		logic              seg;
		logic [AW-1:0]     addr;
	} scan_req_t;

	typedef struct packed {
		logic [AW-1:0]      addr;
		logic [COUNT_W-1:0] number;
		logic               limit;
	} match_t;

	// How a request's outcome is checked: by the predictor, or typed in
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_MATCH} row_check_e;

	typedef struct packed {
		row_check_e check;
		scan_req_t  req;
		match_t     result;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mbps_scan_if  #(.ADDR_W(AW)) scan_in ();
	mbps_match_if #(.ADDR_W(AW)) match_out ();
	mbps_cfg_if                  cfg ();

	masked_byte_pattern_scanner_core #(
		.PATTERN_MAX (PMAX),
		.ADDRESS_BITS(AW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_in  (scan_in),
		.match_out(match_out),
		.cfg      (cfg)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor state
	logic [7:0]         want_byte [PMAX] = '{default: '0};
	logic [7:0]         care_mask [PMAX] = '{default: '0};
	logic [7:0]         history [PMAX] = '{default: '0};
	int unsigned        fill_level;
	logic [COUNT_W-1:0] hit_count;
	logic [PLEN_W-1:0]  cfg_length;
	logic [COUNT_W-1:0] cfg_limit;

	match_t      pending_matches [$];
	int unsigned error_count;
	int unsigned idle_cycles = 0;
	logic        calm;
	logic        hold_off_request;
	logic [AW-1:0] next_addr;

	// Directed requests, pattern length 1 and no match limit
	dir_row_t directed_rows [18] = '{
		'{CHK_NONE,  '{CMD_LOAD,   5'd0,  8'h00, 8'h00, 1'b0, 48'h0}, '0},
		'{CHK_MATCH, '{CMD_SCAN,   5'd0,  8'h00, 8'h00, 1'b1, 48'h0000_0000_0000},
			'{48'h0000_0000_0000, 32'd1, 1'b0}},
		'{CHK_MATCH, '{CMD_SCAN,   5'd31, 8'hFF, 8'hFF, 1'b0, 48'hFFFF_FFFF_FFFF},
			'{48'hFFFF_FFFF_FFFF, 32'd2, 1'b0}},
		// unused command leaves window and count alone
		'{CHK_NONE,  '{CMD_UNUSED, 5'd31, 8'hFF, 8'hFF, 1'b1, 48'hFFFF_FFFF_FFFF}, '0},
		'{CHK_MATCH, '{CMD_SCAN,   5'd0,  8'h5A, 8'h00, 1'b0, 48'h0000_0000_0001},
			'{48'h0000_0000_0001, 32'd3, 1'b0}},
		'{CHK_NONE,  '{CMD_CLEAR,  5'd31, 8'hFF, 8'hFF, 1'b1, 48'hFFFF_FFFF_FFFF}, '0},
		'{CHK_MATCH, '{CMD_SCAN,   5'd0,  8'h3C, 8'h00, 1'b1, 48'h0000_1234_5678},
			'{48'h0000_1234_5678, 32'd1, 1'b0}},
		'{CHK_NONE,  '{CMD_LOAD,   5'd0,  8'hA5, 8'hFF, 1'b0, 48'h0}, '0},
		'{CHK_MATCH, '{CMD_SCAN,   5'd0,  8'hA5, 8'h00, 1'b0, 48'h0000_1234_5679},
			'{48'h0000_1234_5679, 32'd2, 1'b0}},
		'{CHK_NONE,  '{CMD_SCAN,   5'd0,  8'hA4, 8'h00, 1'b0, 48'h0000_1234_567A}, '0},
		// pattern byte with a bit outside its care mask never matches
		'{CHK_NONE,  '{CMD_LOAD,   5'd0,  8'h81, 8'h7F, 1'b0, 48'h0}, '0},
		'{CHK_NONE,  '{CMD_SCAN,   5'd0,  8'h81, 8'h00, 1'b0, 48'h0000_1234_567B}, '0},
		'{CHK_NONE,  '{CMD_SCAN,   5'd0,  8'hFF, 8'h00, 1'b0, 48'h0000_1234_567C}, '0},
		'{CHK_NONE,  '{CMD_LOAD,   5'd31, 8'hFF, 8'hFF, 1'b0, 48'h0}, '0},
		'{CHK_NONE,  '{CMD_LOAD,   5'd0,  8'h80, 8'h80, 1'b0, 48'h0}, '0},
		'{CHK_MODEL, '{CMD_SCAN,   5'd0,  8'h80, 8'h00, 1'b1, 48'h8000_0000_0000}, '0},
		'{CHK_MODEL, '{CMD_SCAN,   5'd0,  8'h7F, 8'h00, 1'b0, 48'h8000_0000_0001}, '0},
		'{CHK_MODEL, '{CMD_SCAN,   5'd0,  8'hFE, 8'h00, 1'b0, 48'h8000_0000_0002}, '0}
	};

	// Mostly no gap, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	// Pattern length in effect: zero acts as one, oversize as the maximum
	function automatic int unsigned active_length();
		if (cfg_length == 0) return 1;
		if (cfg_length > PMAX) return PMAX;
		return cfg_length;
	endfunction

	// Queue a match the core is expected to deliver, oldest first
	function automatic void note_match(input match_t m);
		pending_matches.insert(pending_matches.size(), m);
	endfunction

	// Apply one accepted request to the predictor; return 1 with the match it reports
	function automatic bit compute_match(input scan_req_t r, output match_t m);
		int unsigned n;
		int unsigned i;
		bit hit;
		hit = 1'b0;
		m = '0;
		case (r.cmd)
			CMD_CLEAR: begin
				fill_level = 0;
				hit_count = '0;
			end
			CMD_LOAD: begin
				want_byte[r.pidx] = r.value;
				care_mask[r.pidx] = r.mask;
			end
			CMD_SCAN: begin
				if (r.seg) fill_level = 0;
				for (i = PMAX - 1; i > 0; i--) history[i] = history[i - 1];
				history[0] = r.value;
				if (fill_level < PMAX) fill_level++;
				n = active_length();
				// compare oldest window byte against pattern position 0
				if (fill_level >= n && !(cfg_limit != 0 && hit_count >= cfg_limit)) begin
					hit = 1'b1;
					for (i = 0; i < n; i++)
						if ((history[n - 1 - i] & care_mask[i]) != want_byte[i]) hit = 1'b0;
				end
				if (hit) begin
					if (hit_count != '1) hit_count++;
					m.addr = r.addr - AW'(n - 1);
					m.number = hit_count;
					m.limit = (cfg_limit != 0) && (hit_count == cfg_limit);
				end
			end
			default: ;
		endcase
		return hit;
	endfunction

	function automatic scan_req_t random_request(input logic [CMD_W-1:0] cmd);
		scan_req_t r;
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		r.cmd = cmd;
		r.pidx = PIDX_W'($urandom);
		r.value = 8'($urandom);
		r.mask = 8'($urandom);
		r.seg = 1'($urandom);
		r.addr = wide[AW-1:0];
		return r;
	endfunction

	// Pattern load; a clean one keeps the byte inside its care mask
	function automatic scan_req_t make_load(input logic clean);
		scan_req_t r;
		int unsigned roll;
		r = random_request(CMD_LOAD);
		roll = $urandom_range(0, 9);
		if (roll < 3) r.mask = 8'h00;
		else if (roll < 7) r.mask = 8'hFF;
		if (clean) r.value = r.value & r.mask;
		return r;
	endfunction

	// Scan byte at the next address of the current segment
	function automatic scan_req_t make_scan(input logic [7:0] value, input logic seg);
		scan_req_t r;
		int unsigned roll;
		r = random_request(CMD_SCAN);
		r.value = value;
		r.seg = seg;
		if (seg) begin
			roll = $urandom_range(0, 9);
			// segments at the bottom and top of memory make the window start wrap
			if (roll < 2) next_addr = AW'($urandom_range(0, 40));
			else if (roll < 4) next_addr = '1 - AW'($urandom_range(0, 40));
			else next_addr = r.addr;
		end
		r.addr = next_addr;
		next_addr = next_addr + AW'(1);
		return r;
	endfunction

	// Offer one request, wait for it to be taken, record what it should report
	task automatic offer(input scan_req_t r, input row_check_e check, input match_t typed);
		int unsigned gap;
		match_t m;
		bit hit;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			scan_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_in.valid         <= 1'b1;
		scan_in.command       <= r.cmd;
		scan_in.pattern_index <= r.pidx;
		scan_in.byte_value    <= r.value;
		scan_in.byte_mask     <= r.mask;
		scan_in.segment_start <= r.seg;
		scan_in.byte_address  <= r.addr;
		@(posedge clk);
		while (!scan_in.ready) @(posedge clk);
		hit = compute_match(r, m);
		if (check == CHK_MATCH) note_match(typed);
		else if (check == CHK_MODEL && hit) note_match(m);
	endtask

	// Drop valid, wait for every expected match, then let the pipeline empty
	task automatic settle();
		scan_in.valid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; call only while the core is idle
	task automatic write_config(input logic [PLEN_W-1:0] length,
			input logic [COUNT_W-1:0] limit);
		cfg.valid <= 1'b1;
		cfg.index <= REG_PATTERN_LENGTH;
		cfg.data  <= CFG_DATA_W'(length);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg_length = length;
		cfg.index <= REG_MAX_MATCHES;
		cfg.data  <= limit;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg_limit = limit;
		cfg.valid <= 1'b0;
	endtask

	// One setting of the registers followed by random traffic
	task automatic run_phase(input logic [PLEN_W-1:0] length, input logic [COUNT_W-1:0] limit,
			input int unsigned budget, input logic quiet, input logic squeeze);
		int unsigned sent;
		int unsigned n;
		int unsigned roll;
		int unsigned lead;
		int unsigned k;
		logic [7:0] b;
		settle();
		write_config(length, limit);
		calm = quiet;
		if (squeeze) hold_off_request = 1'b1;
		sent = 0;
		while (sent < budget) begin
			roll = $urandom_range(0, 99);
			n = active_length();
			if (roll < 8) begin
				offer(make_load($urandom_range(0, 9) != 0), CHK_MODEL, '0);
				sent++;
			end else if (roll < 11) begin
				offer(random_request(CMD_CLEAR), CHK_MODEL, '0);
				sent++;
			end else if (roll < 14) begin
				// ignored by the core, not counted
				offer(random_request(CMD_UNUSED), CHK_MODEL, '0);
			end else if (roll < 30) begin
				offer(make_scan(8'($urandom), $urandom_range(0, 3) == 0), CHK_MODEL, '0);
				sent++;
			end else begin
				// plant the pattern after a short lead-in, last byte sometimes spoiled
				lead = $urandom_range(0, 2);
				for (k = 0; k < lead + n; k++) begin
					if (k < lead) b = 8'($urandom);
					else b = want_byte[k - lead] | (8'($urandom) & ~care_mask[k - lead]);
					if (k == lead + n - 1 && $urandom_range(0, 4) == 0)
						b = b ^ (8'h01 << $urandom_range(0, 7));
					offer(make_scan(b, k == 0 && $urandom_range(0, 2) != 0), CHK_MODEL, '0);
					sent++;
				end
			end
		end
	endtask

	// Output side pacing: random stalls, plus a long hold-off on request
	initial begin : sink_pacing
		int unsigned hold;
		hold = 0;
		match_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold == 0) begin
				if (hold_off_request) begin
					hold_off_request = 1'b0;
					hold = HOLD_OFF_CYCLES;
				end else if (!calm) begin
					hold = pick_gap();
				end
			end
			if (hold != 0) begin
				match_out.ready <= 1'b0;
				hold--;
			end else begin
				match_out.ready <= 1'b1;
			end
		end
	end

	// Compare each delivered match with the oldest expectation
	always @(posedge clk) begin : check_matches
		match_t want;
		if (arst_n && match_out.valid && match_out.ready) begin
			if (pending_matches.size() == 0) begin
				$error("unexpected match: match_address %h match_number %0d",
					match_out.match_address, match_out.match_number);
				error_count++;
			end else begin
				want = pending_matches.pop_front();
				if (match_out.match_address !== want.addr) begin
					$error("match_address: expected %h, got %h", want.addr,
						match_out.match_address);
					error_count++;
				end
				if (match_out.match_number !== want.number) begin
					$error("match_number: expected %0d, got %0d", want.number,
						match_out.match_number);
					error_count++;
				end
				if (match_out.limit_reached !== want.limit) begin
					$error("limit_reached: expected %b, got %b", want.limit,
						match_out.limit_reached);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((scan_in.valid && scan_in.ready) || (match_out.valid && match_out.ready)
					|| (cfg.valid && cfg.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		scan_req_t r;
		int unsigned i;
		arst_n                <= 1'b0;
		scan_in.valid         <= 1'b0;
		scan_in.command       <= CMD_CLEAR;
		scan_in.pattern_index <= '0;
		scan_in.byte_value    <= '0;
		scan_in.byte_mask     <= '0;
		scan_in.segment_start <= 1'b0;
		scan_in.byte_address  <= '0;
		cfg.valid             <= 1'b0;
		cfg.index             <= REG_PATTERN_LENGTH;
		cfg.data              <= '0;
		fill_level = 0;
		hit_count = '0;
		cfg_length = PLEN_W'(1);
		cfg_limit = '0;
		error_count = 0;
		calm = 1'b0;
		hold_off_request = 1'b0;
		next_addr = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset settings
		write_config(PLEN_W'(1), '0);
		foreach (directed_rows[j])
			offer(directed_rows[j].req, directed_rows[j].check, directed_rows[j].result);
		settle();

		// load every pattern entry so later scans only compare written entries
		for (i = 0; i < PMAX; i++) begin
			r = make_load(1'b1);
			r.pidx = PIDX_W'(i);
			offer(r, CHK_MODEL, '0);
		end

		run_phase(PLEN_W'(1), '0, 22, 1'b1, 1'b1);
		run_phase(PLEN_W'(4), '0, 28, 1'b0, 1'b0);
		run_phase(PLEN_W'(0), 32'd3, 22, 1'b0, 1'b0);
		run_phase(PLEN_W'(32), '0, 84, 1'b0, 1'b0);
		run_phase(PLEN_W'(63), 32'd5, 84, 1'b1, 1'b0);
		run_phase(PLEN_W'(8), 32'd1, 36, 1'b0, 1'b1);
		run_phase(PLEN_W'(2), 32'hFFFF_FFFF, 24, 1'b0, 1'b0);
		run_phase(PLEN_W'(16), 32'd2, 52, 1'b0, 1'b0);
		run_phase(PLEN_W'(3), '0, 26, 1'b1, 1'b0);
		run_phase(PLEN_W'(5), 32'd7, 30, 1'b0, 1'b0);
		settle();

		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
